// ----- hw/rtl/cpwq_pkg.sv -----
// shared constants, types and command/status structs of the parameter write-back queue
package cpwq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int AW          = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_W       = 8;
    localparam int VAL_W       = 16;
    localparam int CNT_W       = 20;
    localparam int PEND_W      = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CNT_W-1:0] FLUSH_RESET = CNT_W'(50000);
    localparam logic [CNT_W-1:0] RETRY_RESET = CNT_W'(25000);

    localparam logic [CFG_IDX_W-1:0] REG_FLUSH_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_RELOAD = CFG_IDX_W'(1);

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // flush phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_CLAIMED = 2'd1;
    localparam logic [1:0] PH_WAIT    = 2'd2;

    typedef struct packed {
        logic capture;
        logic search;
        logic insert;
        logic tick;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_tick;
        logic in_num_zero;
        logic hit;
        logic k_last;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/cpwq_ctrl.sv -----
// controller state machine: sequences accept, slot search, insert, tick and result load
module cpwq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cpwq_pkg::t_stat   i_stat,
    output cpwq_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_INSERT,
        ST_TICK,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.in_tick) begin
                        n_state = ST_TICK;
                    end else if (i_stat.in_num_zero) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.hit) begin
                    n_state = ST_FINISH;
                end else if (i_stat.k_last) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_TICK: begin
                o_cmd.tick = 1'b1;
                n_state    = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state != ST_IDLE))
        else $error("request accepted but controller stayed idle");
    a_search_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH && i_stat.k_last && !i_stat.hit) |=> (r_state == ST_INSERT))
        else $error("search past last slot did not go to insert");
`endif

endmodule

// ----- hw/rtl/cpwq_dpath.sv -----
// datapath: slot store, ring pointers, flush timer, config registers and result register
module cpwq_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cpwq_pkg::t_cmd                    i_cmd,
    output cpwq_pkg::t_stat                   o_stat,
    input  logic                              i_mode,
    input  logic [cpwq_pkg::NUM_W-1:0]        i_num,
    input  logic [cpwq_pkg::VAL_W-1:0]        i_val,
    input  logic                              i_taken,
    input  logic                              i_done,
    input  logic                              i_cfg_we,
    input  logic [cpwq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cpwq_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_write_valid,
    output logic [7:0]                        o_addr_low,
    output logic [7:0]                        o_data_high,
    output logic [7:0]                        o_data_low,
    output logic [cpwq_pkg::PEND_W-1:0]       o_pending_count,
    output logic                              o_add_dropped,
    output logic                              o_bus_owned
);

    localparam int AW    = cpwq_pkg::AW;
    localparam int OCC_W = cpwq_pkg::OCC_W;
    localparam int NUM_W = cpwq_pkg::NUM_W;
    localparam int VAL_W = cpwq_pkg::VAL_W;
    localparam int CNT_W = cpwq_pkg::CNT_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(cpwq_pkg::QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(cpwq_pkg::QUEUE_DEPTH);

    logic [NUM_W-1:0] r_slot_num [cpwq_pkg::QUEUE_DEPTH];
    logic [VAL_W-1:0] r_slot_val [cpwq_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    r_tail;
    logic [AW-1:0]    r_k;
    logic [OCC_W-1:0] r_occ;
    logic [1:0]       r_phase;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_flush_period;
    logic [CNT_W-1:0] r_retry_reload;
    logic             r_out_valid;

    // captured request and pending result
    logic             r_mode;
    logic [NUM_W-1:0] r_num;
    logic [VAL_W-1:0] r_val;
    logic             r_taken;
    logic             r_done;
    logic             r_res_wv;
    logic [7:0]       r_res_alo;
    logic [7:0]       r_res_dhi;
    logic [7:0]       r_res_dlo;
    logic             r_res_drop;

    logic                      r_out_wv;
    logic [7:0]                r_out_alo;
    logic [7:0]                r_out_dhi;
    logic [7:0]                r_out_dlo;
    logic [cpwq_pkg::PEND_W-1:0] r_out_pend;
    logic                      r_out_drop;
    logic                      r_out_owned;

    logic [AW-1:0]    w_rd_addr;
    logic [NUM_W-1:0] w_rd_num;
    logic [VAL_W-1:0] w_rd_val;
    logic             w_hit;
    logic             w_tail_free;
    logic             w_free_head;
    logic [CNT_W-1:0] w_cnt_inc;
    logic             w_expired;
    logic             w_we;
    logic [AW-1:0]    w_wa;
    logic [NUM_W-1:0] w_wnum;
    logic [VAL_W-1:0] w_wval;
    logic             w_out_free;

    // single read port: search index, tail on insert, head on tick
    always_comb begin
        if (i_cmd.insert) begin
            w_rd_addr = r_tail;
        end else if (i_cmd.tick) begin
            w_rd_addr = r_head;
        end else begin
            w_rd_addr = r_k;
        end
    end

    assign w_rd_num    = r_slot_num[w_rd_addr];
    assign w_rd_val    = r_slot_val[w_rd_addr];
    assign w_hit       = (w_rd_num == r_num);
    assign w_tail_free = (w_rd_num == '0);
    assign w_free_head = i_cmd.tick && (r_phase == cpwq_pkg::PH_WAIT) && r_done;
    assign w_cnt_inc   = (r_cnt != '1) ? r_cnt + CNT_W'(1) : r_cnt;
    assign w_expired   = (w_cnt_inc >= r_flush_period);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // single write port
    always_comb begin
        w_we   = 1'b0;
        w_wa   = r_k;
        w_wnum = r_num;
        w_wval = r_val;
        if (i_cmd.search && w_hit) begin
            w_we = 1'b1;
        end else if (i_cmd.insert && w_tail_free) begin
            w_we = 1'b1;
            w_wa = r_tail;
        end else if (w_free_head) begin
            w_we   = 1'b1;
            w_wa   = r_head;
            w_wnum = '0;
            w_wval = '0;
        end
    end

    assign o_stat.in_tick     = (i_mode == cpwq_pkg::MODE_TICK);
    assign o_stat.in_num_zero = (i_num == '0);
    assign o_stat.hit         = w_hit;
    assign o_stat.k_last      = (r_k == LAST_IDX);
    assign o_stat.out_free    = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cpwq_pkg::QUEUE_DEPTH; i++) begin
                r_slot_num[i] <= '0;
                r_slot_val[i] <= '0;
            end
            r_head         <= '0;
            r_tail         <= '0;
            r_k            <= '0;
            r_occ          <= '0;
            r_phase        <= cpwq_pkg::PH_IDLE;
            r_cnt          <= '0;
            r_flush_period <= cpwq_pkg::FLUSH_RESET;
            r_retry_reload <= cpwq_pkg::RETRY_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == cpwq_pkg::REG_FLUSH_PERIOD) begin
                    r_flush_period <= i_cfg_data;
                end else if (i_cfg_index == cpwq_pkg::REG_RETRY_RELOAD) begin
                    r_retry_reload <= i_cfg_data;
                end
            end
            if (w_we) begin
                r_slot_num[w_wa] <= w_wnum;
                r_slot_val[w_wa] <= w_wval;
            end
            if (i_cmd.capture) begin
                r_k <= '0;
            end else if (i_cmd.search) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.insert && w_tail_free) begin
                r_tail <= (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
                if (r_occ < OCC_MAX) begin
                    r_occ <= r_occ + OCC_W'(1);
                end
            end
            if (i_cmd.tick) begin
                case (r_phase)
                    cpwq_pkg::PH_CLAIMED: begin
                        r_phase <= cpwq_pkg::PH_WAIT;
                    end
                    cpwq_pkg::PH_WAIT: begin
                        if (r_done) begin
                            r_head  <= (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                            r_phase <= cpwq_pkg::PH_IDLE;
                            if (r_occ != '0) begin
                                r_occ <= r_occ - OCC_W'(1);
                            end
                        end
                    end
                    default: begin
                        if (w_expired && !r_taken && (r_occ != '0)) begin
                            r_phase <= cpwq_pkg::PH_CLAIMED;
                        end else begin
                            r_phase <= cpwq_pkg::PH_IDLE;
                        end
                        if (w_expired) begin
                            if (!r_taken) begin
                                r_cnt <= '0;
                            end else begin
                                r_cnt <= r_retry_reload;
                            end
                        end else begin
                            r_cnt <= w_cnt_inc;
                        end
                    end
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= i_mode;
            r_num      <= i_num;
            r_val      <= i_val;
            r_taken    <= i_taken;
            r_done     <= i_done;
            r_res_wv   <= 1'b0;
            r_res_alo  <= '0;
            r_res_dhi  <= '0;
            r_res_dlo  <= '0;
            r_res_drop <= 1'b0;
        end
        if (i_cmd.insert && !w_tail_free) begin
            r_res_drop <= 1'b1;
        end
        if (i_cmd.tick && r_phase == cpwq_pkg::PH_CLAIMED) begin
            r_res_wv  <= 1'b1;
            r_res_alo <= {w_rd_num[6:0], 1'b0};
            r_res_dhi <= w_rd_val[15:8];
            r_res_dlo <= w_rd_val[7:0];
        end
        if (i_cmd.load_out) begin
            r_out_wv    <= r_res_wv;
            r_out_alo   <= r_res_alo;
            r_out_dhi   <= r_res_dhi;
            r_out_dlo   <= r_res_dlo;
            r_out_pend  <= (r_occ > OCC_W'(15)) ? 4'd15 : 4'(r_occ);
            r_out_drop  <= r_res_drop;
            r_out_owned <= (r_phase != cpwq_pkg::PH_IDLE);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_valid   = r_out_wv;
    assign o_addr_low      = r_out_alo;
    assign o_data_high     = r_out_dhi;
    assign o_data_low      = r_out_dlo;
    assign o_pending_count = r_out_pend;
    assign o_add_dropped   = r_out_drop;
    assign o_bus_owned     = r_out_owned;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_MAX)
        else $error("occupancy above queue depth");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_head == r_tail))
        else $error("empty ring with head and tail apart");
    a_write_owns_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_wv) |-> r_out_owned)
        else $error("write issued without bus ownership");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");
    a_tick_only_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick |-> (r_mode == cpwq_pkg::MODE_TICK))
        else $error("tick step on an add request");
`endif

endmodule

// ----- hw/rtl/coalescing_param_writeback_queue.sv -----
// top level of the coalescing parameter write-back queue
// An add request passes from acceptance to its result being loaded through
// these steps: accept, compare one slot at a time while searching the ring
// for the same parameter number (up to the queue depth, 8), check the tail on
// a miss, and load the result register once the output register is free. A
// tick request steps through accept, tick and load; an add with number zero
// goes from accept straight to load. The slot search walks the store through
// its single read port. One request is worked on at a time; the next is
// accepted while the previous result waits in the output register. Config
// writes are registered and are meant to be made while no request is in progress.
module coalescing_param_writeback_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // param_number[7:0], param_value[23:8], bus_taken[24], write_done[25]
    input  logic [cpwq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // mode[0]
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // addr_low[7:0], data_high[15:8], data_low[23:16], pending_count[27:24],
    // add_dropped[28], bus_owned[29]
    output logic [cpwq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // write_valid[0]
    output logic [0:0]                           m_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [cpwq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cpwq_pkg::CNT_W-1:0]           i_cfg_data
);

    cpwq_pkg::t_cmd  w_cmd;
    cpwq_pkg::t_stat w_stat;

    logic                          w_write_valid;
    logic [7:0]                    w_addr_low;
    logic [7:0]                    w_data_high;
    logic [7:0]                    w_data_low;
    logic [cpwq_pkg::PEND_W-1:0]   w_pending_count;
    logic                          w_add_dropped;
    logic                          w_bus_owned;

    cpwq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cpwq_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_mode          (s_axis_tuser[0]),
        .i_num           (s_axis_tdata[7:0]),
        .i_val           (s_axis_tdata[23:8]),
        .i_taken         (s_axis_tdata[24]),
        .i_done          (s_axis_tdata[25]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_write_valid   (w_write_valid),
        .o_addr_low      (w_addr_low),
        .o_data_high     (w_data_high),
        .o_data_low      (w_data_low),
        .o_pending_count (w_pending_count),
        .o_add_dropped   (w_add_dropped),
        .o_bus_owned     (w_bus_owned)
    );

    assign m_axis_tuser = w_write_valid;
    assign m_axis_tdata = {2'b00, w_bus_owned, w_add_dropped, w_pending_count,
                           w_data_low, w_data_high, w_addr_low};

endmodule

// ----- tb/coalescing_param_writeback_queue_tb.sv -----
// testbench for the parameter write-back queue: directed and random requests
`timescale 1ns / 1ps

typedef struct packed {
    logic                       mode;
    logic [cpwq_pkg::NUM_W-1:0] num;
    logic [cpwq_pkg::VAL_W-1:0] val;
    logic                       taken;
    logic                       done;
} t_param_req;

typedef struct packed {
    logic                        wr_valid;
    logic [7:0]                  addr_lo;
    logic [7:0]                  dat_hi;
    logic [7:0]                  dat_lo;
    logic [cpwq_pkg::PEND_W-1:0] pend;
    logic                        dropped;
    logic                        owned;
} t_flush_status;

class writeback_tracker;
    logic [cpwq_pkg::NUM_W-1:0] slot_num [cpwq_pkg::QUEUE_DEPTH];
    logic [cpwq_pkg::VAL_W-1:0] slot_val [cpwq_pkg::QUEUE_DEPTH];
    int                         head;
    int                         tail;
    int                         occ;
    logic [1:0]                 phase;
    logic [cpwq_pkg::CNT_W-1:0] ticks;
    logic [cpwq_pkg::CNT_W-1:0] period;
    logic [cpwq_pkg::CNT_W-1:0] retry;
    t_flush_status              owed_status [$];
    int                         errors;
    int                         mismatches;
    int                         n_req;
    int                         n_writes;
    int                         n_drops;
    int                         n_updates;
    int                         n_cfg;

    function new();
        foreach (slot_num[k]) begin
            slot_num[k] = '0;
            slot_val[k] = '0;
        end
        head   = 0;
        tail   = 0;
        occ    = 0;
        phase  = cpwq_pkg::PH_IDLE;
        ticks  = '0;
        period = cpwq_pkg::FLUSH_RESET;
        retry  = cpwq_pkg::RETRY_RESET;
    endfunction

    function int next_slot(int i);
        return (i == cpwq_pkg::QUEUE_DEPTH - 1) ? 0 : i + 1;
    endfunction

    function void write_reg(logic [cpwq_pkg::CFG_IDX_W-1:0] idx,
                            logic [cpwq_pkg::CNT_W-1:0] data);
        n_cfg++;
        if (idx == cpwq_pkg::REG_FLUSH_PERIOD) begin
            period = data;
        end else if (idx == cpwq_pkg::REG_RETRY_RELOAD) begin
            retry = data;
        end
    endfunction

    // works out the status word that one accepted request produces
    function void take_request(t_param_req r);
        t_flush_status e;
        bit            hit;
        e   = '0;
        hit = 1'b0;
        n_req++;
        if (r.mode == cpwq_pkg::MODE_ADD) begin
            if (r.num != '0) begin
                for (int k = 0; k < cpwq_pkg::QUEUE_DEPTH; k++) begin
                    if (!hit && slot_num[k] == r.num) begin
                        slot_val[k] = r.val;
                        hit = 1'b1;
                        n_updates++;
                    end
                end
                if (!hit) begin
                    if (slot_num[tail] == '0) begin
                        slot_num[tail] = r.num;
                        slot_val[tail] = r.val;
                        tail = next_slot(tail);
                        if (occ < cpwq_pkg::QUEUE_DEPTH) occ++;
                    end else begin
                        e.dropped = 1'b1;
                        n_drops++;
                    end
                end
            end
        end else begin
            case (phase)
                cpwq_pkg::PH_CLAIMED: begin
                    e.wr_valid = 1'b1;
                    e.addr_lo  = {slot_num[head][6:0], 1'b0};
                    e.dat_hi   = slot_val[head][15:8];
                    e.dat_lo   = slot_val[head][7:0];
                    phase      = cpwq_pkg::PH_WAIT;
                    n_writes++;
                end
                cpwq_pkg::PH_WAIT: begin
                    if (r.done) begin
                        slot_num[head] = '0;
                        slot_val[head] = '0;
                        head  = next_slot(head);
                        if (occ > 0) occ--;
                        phase = cpwq_pkg::PH_IDLE;
                    end
                end
                default: begin
                    phase = cpwq_pkg::PH_IDLE;
                    if (ticks != '1) ticks++;
                    if (ticks >= period) begin
                        if (!r.taken) begin
                            ticks = '0;
                            if (occ != 0) phase = cpwq_pkg::PH_CLAIMED;
                        end else begin
                            ticks = retry;
                        end
                    end
                end
            endcase
        end
        e.pend  = (occ > 15) ? cpwq_pkg::PEND_W'(15) : cpwq_pkg::PEND_W'(occ);
        e.owned = (phase != cpwq_pkg::PH_IDLE);
        owed_status.push_back(e);
    endfunction

    function void check_status(t_flush_status got);
        t_flush_status e;
        if (owed_status.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: status with no request outstanding: wv=%0d addr=%02h",
                         $time, got.wr_valid, got.addr_lo,
                         " data=%02h%02h pend=%0d drop=%0d own=%0d",
                         got.dat_hi, got.dat_lo, got.pend, got.dropped, got.owned);
            return;
        end
        e = owed_status.pop_front();
        if (got.wr_valid !== e.wr_valid || got.addr_lo !== e.addr_lo ||
            got.dat_hi !== e.dat_hi || got.dat_lo !== e.dat_lo ||
            got.pend !== e.pend || got.dropped !== e.dropped ||
            got.owned !== e.owned) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: status mismatch, expected wv=%0d addr=%02h", $time,
                         e.wr_valid, e.addr_lo,
                         " data=%02h%02h pend=%0d drop=%0d own=%0d",
                         e.dat_hi, e.dat_lo, e.pend, e.dropped, e.owned);
                $display("%0t:                  actual   wv=%0d addr=%02h", $time,
                         got.wr_valid, got.addr_lo,
                         " data=%02h%02h pend=%0d drop=%0d own=%0d",
                         got.dat_hi, got.dat_lo, got.pend, got.dropped, got.owned);
            end
        end
    endfunction

    function void close_out();
        errors += owed_status.size();
        if (owed_status.size() != 0)
            $display("%0t: %0d status words never arrived", $time, owed_status.size());
    endfunction
endclass

module coalescing_param_writeback_queue_tb;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEM_THIRD    = 225;
    localparam int NUM_W         = cpwq_pkg::NUM_W;
    localparam int VAL_W         = cpwq_pkg::VAL_W;
    localparam int CNT_W         = cpwq_pkg::CNT_W;
    localparam int CFG_IDX_W     = cpwq_pkg::CFG_IDX_W;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [cpwq_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]                       s_axis_tuser  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [cpwq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]                       m_axis_tuser;
    logic                             i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]             i_cfg_index   = '0;
    logic [CNT_W-1:0]                 i_cfg_data    = '0;

    writeback_tracker model;
    int               tx_idle_pct = 31;
    int               rx_idle_pct = 56;
    int               sent        = 0;
    int               stall_cycles = 0;

    coalescing_param_writeback_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // request capture, status check and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                model.take_request({s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[23:8],
                                    s_axis_tdata[24], s_axis_tdata[25]});
            if (m_axis_tvalid && m_axis_tready)
                model.check_status({m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[15:8],
                                    m_axis_tdata[23:16], m_axis_tdata[27:24],
                                    m_axis_tdata[28], m_axis_tdata[29]});
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("coalescing_param_writeback_queue_tb failed");
            $finish;
        end
    end

    function automatic t_param_req req(logic mode, int num, int val, bit taken, bit done);
        t_param_req r;
        r.mode  = mode;
        r.num   = NUM_W'(num);
        r.val   = VAL_W'(val);
        r.taken = taken;
        r.done  = done;
        return r;
    endfunction

    function automatic t_param_req rand_request();
        t_param_req r;
        int         pick;
        pick   = $urandom_range(99);
        r.mode = ($urandom_range(99) < 50) ? cpwq_pkg::MODE_TICK : cpwq_pkg::MODE_ADD;
        // mostly a small pool of numbers so that updates and drops happen often
        if (pick < 5) begin
            r.num = '0;
        end else if (pick < 75) begin
            r.num = NUM_W'($urandom_range(12, 1));
        end else if (pick < 85) begin
            case ($urandom_range(3))
                0:       r.num = 8'h01;
                1:       r.num = 8'h7F;
                2:       r.num = 8'h80;
                default: r.num = 8'hFF;
            endcase
        end else begin
            r.num = NUM_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 5)       r.val = '0;
        else if (pick < 10) r.val = '1;
        else                r.val = VAL_W'($urandom);
        r.taken = ($urandom_range(99) < 25);
        r.done  = ($urandom_range(99) < 45);
        return r;
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input t_param_req r);
        tx_idle_pct = (sent < ITEM_THIRD) ? 31 : (sent < 2 * ITEM_THIRD) ? 56 : 0;
        rx_idle_pct = (sent < ITEM_THIRD) ? 56 : (sent < 2 * ITEM_THIRD) ? 31 : 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, r.done, r.taken, r.val, r.num};
        s_axis_tuser  <= r.mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (model.owed_status.size() != 0) @(negedge i_clk);
        // the queue is idle here; pad with idle cycles before the next step
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CNT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic run_random(input logic [CNT_W-1:0] flush, input logic [CNT_W-1:0] reload,
                              input int count);
        settle();
        program_reg(cpwq_pkg::REG_FLUSH_PERIOD, flush);
        program_reg(cpwq_pkg::REG_RETRY_RELOAD, reload);
        repeat (count) send_request(rand_request());
    endtask

    initial begin
        t_param_req plan [$];
        model = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        program_reg(cpwq_pkg::REG_FLUSH_PERIOD, CNT_W'(1));
        program_reg(cpwq_pkg::REG_RETRY_RELOAD, '0);
        // an index past the register list must change nothing
        program_reg(cpwq_pkg::REG_RETRY_RELOAD + CFG_IDX_W'($urandom_range(254, 1)),
                    CNT_W'($urandom));

        plan.push_back(req(cpwq_pkg::MODE_ADD,    0, 'hFFFF, 1, 1));  // number zero is ignored
        plan.push_back(req(cpwq_pkg::MODE_ADD,    1, 'h0000, 0, 0));
        plan.push_back(req(cpwq_pkg::MODE_ADD,  255, 'hFFFF, 1, 0));
        plan.push_back(req(cpwq_pkg::MODE_ADD,  128, 'h8001, 0, 1));  // address wraps to zero
        plan.push_back(req(cpwq_pkg::MODE_ADD,    1, 'h1234, 0, 0));  // coalesced update
        plan.push_back(req(cpwq_pkg::MODE_TICK, 255, 'hFFFF, 1, 0));  // bus taken, reload
        plan.push_back(req(cpwq_pkg::MODE_TICK,   0, 'h0000, 0, 1));  // claims the bus
        plan.push_back(req(cpwq_pkg::MODE_ADD,    1, 'hABCD, 0, 0));  // head updated
        plan.push_back(req(cpwq_pkg::MODE_TICK,  77, 'h5A5A, 1, 0));  // write issued
        plan.push_back(req(cpwq_pkg::MODE_TICK,   0, 'h0000, 0, 0));  // still waiting
        plan.push_back(req(cpwq_pkg::MODE_ADD,    1, 'h5555, 1, 1));  // head updated in flight
        plan.push_back(req(cpwq_pkg::MODE_TICK,   0, 'h0000, 0, 1));  // head freed
        for (int n = 2; n <= 7; n++)
            plan.push_back(req(cpwq_pkg::MODE_ADD, n, n * 'h1111, 0, 0));
        plan.push_back(req(cpwq_pkg::MODE_ADD,    9, 'h0909, 0, 0));  // ring full, dropped
        plan.push_back(req(cpwq_pkg::MODE_ADD,  128, 'h0000, 0, 0));  // update while full
        plan.push_back(req(cpwq_pkg::MODE_TICK,   0, 'h0000, 0, 0));
        plan.push_back(req(cpwq_pkg::MODE_TICK,   0, 'h0000, 0, 0));
        plan.push_back(req(cpwq_pkg::MODE_TICK,   0, 'h0000, 1, 1));
        plan.push_back(req(cpwq_pkg::MODE_ADD,    9, 'h0909, 0, 0));  // tail free again
        foreach (plan[k]) send_request(plan[k]);

        run_random(CNT_W'(1), '0, 150);
        run_random(CNT_W'(3), '1, 150);   // reload above the period drives the counter to its ceiling
        run_random('0, CNT_W'(2), 150);   // zero period expires on every idle tick
        run_random('1, '1, 50);
        run_random(CNT_W'(5), CNT_W'(4), 150);
        settle();

        model.close_out();
        $display("covered %0d requests under %0d register writes with idling on both sides",
                 model.n_req, model.n_cfg);
        $display("%0d memory writes issued, %0d adds dropped, %0d coalesced updates",
                 model.n_writes, model.n_drops, model.n_updates);
        if (model.errors == 0) begin
            $display("coalescing_param_writeback_queue_tb passed");
        end else begin
            $display("coalescing_param_writeback_queue_tb failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cpwq_pkg.sv
hw/rtl/cpwq_ctrl.sv
hw/rtl/cpwq_dpath.sv
hw/rtl/coalescing_param_writeback_queue.sv
tb/coalescing_param_writeback_queue_tb.sv
